FILE: hdl/rtma_pkg.sv
package rtma_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int MAG_W      = 8;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(WINDOW_LEN - 1);
    localparam logic [MAG_W-1:0] MIN_INIT = {MAG_W{1'b1}};
    localparam logic [5:0]       ASCII_ZERO = 6'h30;

    // Reciprocal of ten for values below 100: (x * 205) >> 11
    localparam logic [7:0] RECIP_TEN   = 8'd205;
    localparam int         RECIP_SHIFT = 11;

    // Finished window: sum of all ten magnitudes plus the extremes to drop
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [MAG_W-1:0] max_v;
        logic [MAG_W-1:0] min_v;
    } win_rec_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QLVL_W-1:0] level;
    } q_stat_t;

endpackage

FILE: hdl/rssi_trimmed_mean_ascii_top.sv
// A closed window's record passes the queue, stage 1, stage 2 and the output register.
// Throughput: one reading per cycle when not stalled, one result per ten readings.
// The only stall on the input is the closing beat of a window while the two-entry
// window queue is full, which needs the output held off for several windows.
// Reset (rst_n low, asynchronous): window count, sum and max clear, min goes to 255,
// the queue empties and no result is valid.
module rssi_trimmed_mean_ascii_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rssi_dbm
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] mean_magnitude, [13:8] ascii_hundreds,
                                        // [19:14] ascii_tens, [25:20] ascii_ones, zero pad
);

    rtma_pkg::q_stat_t  q_stat;
    rtma_pkg::win_rec_t push_rec;
    rtma_pkg::win_rec_t pop_rec;
    logic               push;
    logic               pop;
    logic [7:0]         mean_magnitude;
    logic [5:0]         ascii_hundreds;
    logic [5:0]         ascii_tens;
    logic [5:0]         ascii_ones;

    // Front: take each reading, fold its magnitude into the running window,
    // and hand a finished window record to the queue on the tenth beat.
    rtma_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .rssi_dbm ($signed(s_axis_tdata)),
        .q_stat   (q_stat),
        .push     (push),
        .rec      (push_rec)
    );

    // Queue: decouple window accumulation from the digit pipeline.
    rtma_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .stat     (q_stat)
    );

    // Back: trim, average, split into ASCII digits, hold in the output register.
    rtma_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .rec            (pop_rec),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .mean_magnitude (mean_magnitude),
        .ascii_hundreds (ascii_hundreds),
        .ascii_tens     (ascii_tens),
        .ascii_ones     (ascii_ones)
    );

    assign m_axis_tdata = {6'd0, ascii_ones, ascii_tens, ascii_hundreds, mean_magnitude};

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("window queue overflow");

    // Input stalls only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n) !s_axis_tready |-> q_stat.full)
        else $error("input stalled with room in queue");

    // Digits rebuild the mean
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ({2'd0, mean_magnitude} ==
            10'({4'd0, ascii_hundreds - rtma_pkg::ASCII_ZERO} * 10'd100
              + {4'd0, ascii_tens - rtma_pkg::ASCII_ZERO} * 10'd10
              + {4'd0, ascii_ones - rtma_pkg::ASCII_ZERO})))
        else $error("ASCII digits disagree with mean");

    // A result waits while the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

endmodule

FILE: hdl/rtma_front.sv
module rtma_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [7:0]        rssi_dbm,
    input  rtma_pkg::q_stat_t        q_stat,
    output logic                     push,
    output rtma_pkg::win_rec_t       rec
);

    logic [rtma_pkg::CNT_W-1:0] count_reg, count_next;
    logic [rtma_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [rtma_pkg::MAG_W-1:0] max_reg, max_next;
    logic [rtma_pkg::MAG_W-1:0] min_reg, min_next;

    logic [rtma_pkg::MAG_W-1:0] mag;
    logic [rtma_pkg::SUM_W-1:0] sum_add;
    logic [rtma_pkg::MAG_W-1:0] max_upd;
    logic [rtma_pkg::MAG_W-1:0] min_upd;
    logic                       is_last;
    logic                       accept;

    // Stall only the closing beat of a window, and only when the queue is full
    assign is_last  = (count_reg == rtma_pkg::LAST_IDX);
    assign in_ready = !q_stat.full || !is_last;
    assign accept   = in_valid && in_ready;

    // Magnitude is the 8-bit negation; positive readings wrap
    assign mag     = rtma_pkg::MAG_W'(8'd0 - $unsigned(rssi_dbm));
    assign sum_add = sum_reg + {{(rtma_pkg::SUM_W - rtma_pkg::MAG_W){1'b0}}, mag};
    assign max_upd = (mag > max_reg) ? mag : max_reg;
    assign min_upd = (mag < min_reg) ? mag : min_reg;

    assign push = accept && is_last;
    assign rec  = '{sum: sum_add, max_v: max_upd, min_v: min_upd};

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        if (accept)
        begin
            if (is_last)
            begin
                count_next = '0;
                sum_next   = '0;
                max_next   = '0;
                min_next   = rtma_pkg::MIN_INIT;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_add;
                max_next   = max_upd;
                min_next   = min_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= rtma_pkg::MIN_INIT;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
        end
    end

endmodule

FILE: hdl/rtma_queue.sv
module rtma_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rtma_pkg::win_rec_t   push_rec,
    input  logic                 pop,
    output rtma_pkg::win_rec_t   pop_rec,
    output rtma_pkg::q_stat_t    stat
);

    rtma_pkg::win_rec_t entry_reg [rtma_pkg::QUEUE_DEPTH];

    logic [rtma_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rtma_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rtma_pkg::QLVL_W-1:0] level_reg, level_next;
    logic                        do_push;
    logic                        do_pop;

    assign stat.full  = (level_reg == rtma_pkg::QLVL_W'(rtma_pkg::QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;
    assign pop_rec = entry_reg[rd_ptr_reg];

    // Wrap pointers at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rtma_pkg::QPTR_W'(rtma_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rtma_pkg::QPTR_W'(rtma_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: hdl/rtma_back.sv
module rtma_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtma_pkg::q_stat_t    q_stat,
    input  rtma_pkg::win_rec_t   rec,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           mean_magnitude,
    output logic [5:0]           ascii_hundreds,
    output logic [5:0]           ascii_tens,
    output logic [5:0]           ascii_ones
);

    // Stage 1: mean, hundreds digit and remainder below 100
    logic       s1_v_reg, s1_v_next;
    logic [7:0] s1_mean_reg;
    logic [1:0] s1_hund_reg;
    logic [6:0] s1_rem_reg;
    // Stage 2: tens digit through the reciprocal multiply
    logic       s2_v_reg, s2_v_next;
    logic [7:0] s2_mean_reg;
    logic [1:0] s2_hund_reg;
    logic [6:0] s2_rem_reg;
    logic [3:0] s2_tens_reg;
    // Output register
    logic       out_v_reg, out_v_next;
    logic [7:0] out_mean_reg;
    logic [5:0] out_hund_reg;
    logic [5:0] out_tens_reg;
    logic [5:0] out_ones_reg;

    logic        out_take, s2_take, s1_take;
    logic [11:0] diff;
    logic [7:0]  mean;
    logic [1:0]  hund;
    logic [7:0]  rem_full;
    logic [14:0] tens_prod;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;

    assign out_take = !out_v_reg || out_ready;
    assign s2_take  = !s2_v_reg || out_take;
    assign s1_take  = !s1_v_reg || s2_take;
    assign pop      = !q_stat.empty && s1_take;

    // Drop one max and one min, keep eight, shift right by three
    assign diff = rec.sum - {4'd0, rec.max_v} - {4'd0, rec.min_v};
    assign mean = diff[10:3];

    always_comb
    begin
        if (mean >= 8'd200)
        begin
            hund     = 2'd2;
            rem_full = mean - 8'd200;
        end
        else if (mean >= 8'd100)
        begin
            hund     = 2'd1;
            rem_full = mean - 8'd100;
        end
        else
        begin
            hund     = 2'd0;
            rem_full = mean;
        end
    end

    assign tens_prod = {8'd0, s1_rem_reg};

    assign tens_x10  = 7'({3'd0, s2_tens_reg} * 7'd10);
    assign ones_full = s2_rem_reg - tens_x10;

    always_comb
    begin
        s1_v_next  = s1_take ? pop : s1_v_reg;
        s2_v_next  = s2_take ? s1_v_reg : s2_v_reg;
        out_v_next = out_take ? s2_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_mean_reg <= mean;
            s1_hund_reg <= hund;
            s1_rem_reg  <= rem_full[6:0];
        end
        if (s2_take)
        begin
            s2_mean_reg <= s1_mean_reg;
            s2_hund_reg <= s1_hund_reg;
            s2_rem_reg  <= s1_rem_reg;
            s2_tens_reg <= 4'((tens_prod * 15'(rtma_pkg::RECIP_TEN)) >> rtma_pkg::RECIP_SHIFT);
        end
        if (out_take)
        begin
            out_mean_reg <= s2_mean_reg;
            out_hund_reg <= rtma_pkg::ASCII_ZERO + {4'd0, s2_hund_reg};
            out_tens_reg <= rtma_pkg::ASCII_ZERO + {2'd0, s2_tens_reg};
            out_ones_reg <= rtma_pkg::ASCII_ZERO + {2'd0, ones_full[3:0]};
        end
    end

    assign out_valid      = out_v_reg;
    assign mean_magnitude = out_mean_reg;
    assign ascii_hundreds = out_hund_reg;
    assign ascii_tens     = out_tens_reg;
    assign ascii_ones     = out_ones_reg;

endmodule
